@@ rtl/ca3d_generations_step_unit_assert.svh @@
// assertion macros for the ca3d step unit
`ifndef CA3D_GENERATIONS_STEP_UNIT_ASSERT_SVH
`define CA3D_GENERATIONS_STEP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CA3D_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define CA3D_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define CA3D_ASSERT_IMP(label, clk, rst, a, c)
`define CA3D_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

@@ rtl/ca3d_pkg.sv @@
// ----------------------------------------------------------------------------
// ca3d_pkg
// shared sizes and command codes for the 3d generations automaton
// ----------------------------------------------------------------------------
`default_nettype none
package ca3d_pkg;
  localparam int GridX = 16;
  localparam int GridY = 16;
  localparam int GridZ = 16;
  localparam int XW = (GridX > 1) ? $clog2(GridX) : 1;
  localparam int YW = (GridY > 1) ? $clog2(GridY) : 1;
  localparam int ZW = (GridZ > 1) ? $clog2(GridZ) : 1;
  localparam int AW = XW + YW + ZW;
  localparam int Cells = GridX * GridY * GridZ;
  localparam int CntW = 5;
  localparam logic [12:0] CountMax = 13'd8191;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_NBHD  = 2'd0,
    REG_NSTAT = 2'd1,
    REG_BIRTH = 2'd2,
    REG_SURV  = 2'd3
  } reg_t;

  typedef logic [AW-1:0] addr_t;

  function automatic addr_t cell_addr(logic [XW-1:0] x, logic [YW-1:0] y,
                                      logic [ZW-1:0] z);
    cell_addr = {x, y, z};
  endfunction
endpackage
`default_nettype wire

@@ rtl/ca3d_generations_step_unit.sv @@
// Generations-style 3d automaton on a 16x16x16 grid. Every command returns
// one word. A write or an unused command returns it through the wait state;
// an in-grid read first captures the cell memory data, then waits likewise.
// The next word is taken the cycle after the result is accepted. A step
// gathers each cell's full-neighbour count by reading all 27 offsets around
// it, one cell memory read per offset, counting the full cells among its
// in-grid neighbours of the chosen neighbourhood, then writes the count. It
// then applies the rules to each cell in a second pass, reading and then
// writing it. The length of a step is set by the single read port of the
// cell memory. After reset the cell memory is swept to zero before the first word is taken.
// ----------------------------------------------------------------------------
// ca3d_generations_step_unit
// top level: command decode, cell memory sequencer and rule logic
// ----------------------------------------------------------------------------
`default_nettype none
`include "ca3d_generations_step_unit_assert.svh"
module ca3d_generations_step_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [26:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [3:0]  pos_x,
  input  wire logic [3:0]  pos_y,
  input  wire logic [3:0]  pos_z,
  input  wire logic [7:0]  cell_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       cell_state,
  output logic [12:0]      live_count
);
  import ca3d_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_WAIT, S_G_RD, S_G_ACC, S_W_RD, S_W_WR, S_A_RD,
    S_A_WR, S_DONE
  } state_t;

  state_t state;
  logic        neighborhood;
  logic [7:0]  num_states;
  logic [26:0] birth_mask, survive_mask;

  logic        c_we, n_we;
  addr_t       c_waddr, c_raddr, n_waddr, n_raddr;
  logic [7:0]  c_wdata, c_rdata;
  logic [CntW-1:0] n_wdata, n_rdata;

  addr_t      cur;
  logic [1:0] dxc, dyc, dzc;
  logic [CntW-1:0] acc;
  logic [12:0] live;
  logic [AW:0] sweep;

  // cell state memory and neighbour count memory
  ca3d_ram #(.Width(8), .Depth(Cells)) u_cells (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr),
    .rdata(c_rdata));
  ca3d_ram #(.Width(CntW), .Depth(Cells)) u_counts (
    .clk, .we(n_we), .waddr(n_waddr), .wdata(n_wdata), .raddr(n_raddr),
    .rdata(n_rdata));

  // neighbour position from the offset counters, each 0..2 for -1..1
  logic signed [XW+1:0] nx;
  logic signed [YW+1:0] ny;
  logic signed [ZW+1:0] nz;
  logic nb_ok, is_full;
  logic [4:0] nb_span;
  always_comb begin
    nx = $signed({2'b00, cur[AW-1 -: XW]} + {{XW{1'b0}}, dxc} - (XW+2)'(1));
    ny = $signed({2'b00, cur[YW+ZW-1 -: YW]} + {{YW{1'b0}}, dyc} - (YW+2)'(1));
    nz = $signed({2'b00, cur[ZW-1:0]} + {{ZW{1'b0}}, dzc} - (ZW+2)'(1));
    nb_span = 5'(dxc != 2'd1) + 5'(dyc != 2'd1) + 5'(dzc != 2'd1);
    nb_ok = (nb_span != 5'd0) && (neighborhood || nb_span == 5'd1) &&
            nx >= 0 && ny >= 0 && nz >= 0 &&
            nx < GridX && ny < GridY && nz < GridZ;
    is_full = (c_rdata != 8'd0) && (c_rdata == num_states);
  end

  logic in_grid;
  assign in_grid = ({28'd0, pos_x} < GridX) && ({28'd0, pos_y} < GridY) &&
                   ({28'd0, pos_z} < GridZ);
  logic nb_ok_q;

  // rule applied to current cell
  logic [7:0] s_new;
  logic [26:0] bitv;
  always_comb begin
    bitv = (n_rdata < 5'd27) ? (27'd1 << n_rdata) : 27'd0;
    s_new = c_rdata;
    if (c_rdata == 8'd0) begin
      if ((birth_mask & bitv) != 27'd0) s_new = num_states;
    end else if (is_full) begin
      if ((survive_mask & bitv) == 27'd0) s_new = c_rdata - 8'd1;
    end else begin
      s_new = c_rdata - 8'd1;
    end
  end

  // memory port drive
  always_comb begin
    c_we = 1'b0; c_waddr = cur; c_wdata = 8'd0; c_raddr = cur;
    n_we = 1'b0; n_waddr = cur; n_wdata = acc; n_raddr = cur;
    unique case (state)
      S_CLEAR: begin
        c_we = 1'b1; c_waddr = sweep[AW-1:0];
      end
      S_IDLE: begin
        c_raddr = cell_addr(pos_x[XW-1:0], pos_y[YW-1:0], pos_z[ZW-1:0]);
        c_waddr = c_raddr;
        c_wdata = (cell_value > num_states) ? num_states : cell_value;
        c_we = in_valid && in_ready && cmd == CMD_WRITE && in_grid;
      end
      S_G_RD: c_raddr = addr_t'({nx[XW-1:0], ny[YW-1:0], nz[ZW-1:0]});
      S_W_WR: n_we = 1'b1;
      S_A_WR: begin
        c_we = 1'b1; c_wdata = s_new;
      end
      default: ;
    endcase
  end

  // command sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; sweep <= '0; out_valid <= 1'b0;
      neighborhood <= 1'b1; num_states <= 8'd1;
      birth_mask <= 27'd8; survive_mask <= 27'd12;
      cur <= '0; dxc <= '0; dyc <= '0; dzc <= '0; acc <= '0; live <= '0;
      nb_ok_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_t'(cfg_index))
          REG_NBHD:  neighborhood <= cfg_data[0];
          REG_NSTAT: num_states <= cfg_data[7:0];
          REG_BIRTH: birth_mask <= cfg_data;
          REG_SURV:  survive_mask <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == (AW+1)'(Cells - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid && in_ready) begin
          cell_state <= 8'd0; live_count <= 13'd0;
          unique case (cmd_t'(cmd))
            CMD_READ:  state <= in_grid ? S_RD : S_WAIT;
            CMD_STEP: begin
              cur <= '0; dxc <= '0; dyc <= '0; dzc <= '0; acc <= '0; live <= '0;
              state <= S_G_RD;
            end
            default:   state <= S_WAIT;
          endcase
        end
        // read data arrives the cycle after the word is taken
        S_RD: begin
          cell_state <= c_rdata; state <= S_WAIT;
        end
        S_WAIT: begin
          out_valid <= 1'b1; state <= S_IDLE;
        end
        S_G_RD: begin
          nb_ok_q <= nb_ok; state <= S_G_ACC;
        end
        S_G_ACC: begin
          if (nb_ok_q && is_full) acc <= acc + 1'b1;
          if (dxc == 2'd2 && dyc == 2'd2 && dzc == 2'd2) state <= S_W_WR;
          else begin
            state <= S_G_RD;
            if (dzc != 2'd2) dzc <= dzc + 2'd1;
            else begin
              dzc <= 2'd0;
              if (dyc != 2'd2) dyc <= dyc + 2'd1;
              else begin
                dyc <= 2'd0; dxc <= dxc + 2'd1;
              end
            end
          end
        end
        S_W_WR: begin
          dxc <= '0; dyc <= '0; dzc <= '0; acc <= '0;
          if (cur == addr_t'(Cells - 1)) begin
            cur <= '0; state <= S_A_RD;
          end else begin
            cur <= cur + 1'b1; state <= S_G_RD;
          end
        end
        S_A_RD: state <= S_A_WR;
        S_A_WR: begin
          if (s_new != 8'd0 && live != CountMax) live <= live + 1'b1;
          if (cur == addr_t'(Cells - 1)) state <= S_DONE;
          else begin
            cur <= cur + 1'b1; state <= S_A_RD;
          end
        end
        S_DONE: begin
          live_count <= live; out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  `CA3D_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == S_IDLE)
  `CA3D_ASSERT_NXT(a_one_word, clk, rst, in_valid && in_ready, !in_ready)
  `CA3D_ASSERT_IMP(a_acc_range, clk, rst, state == S_G_ACC, acc <= 5'd26)
endmodule
`default_nettype wire

@@ rtl/ca3d_ram.sv @@
// ----------------------------------------------------------------------------
// ca3d_ram
// synchronous ram with one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module ca3d_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
